/* rtl/lpmr_pkg.sv */
// Shared types and constants for the length-prefixed message ring.
// Used by the channel interfaces and every module of the block but lpmr_ram; depends on nothing.
package lpmr_pkg;

  localparam int RingBytes = 4096;

  localparam int KindW   = 2;
  localparam int WLenW   = 12;
  localparam int DataW   = 8;
  localparam int MaxLenW = 13;
  localparam int StatusW = 3;
  localparam int HdrBytes = 4;
  localparam int HdrW    = 8 * HdrBytes;

  // header bytes plus the one byte always kept free
  localparam int HdrSlack = HdrBytes + 1;

  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [KindW-1:0] {
    OpWrHdr  = 2'd0,
    OpWrByte = 2'd1,
    OpRdHdr  = 2'd2,
    OpRdByte = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StTooLong  = 3'd2,
    StTooLarge = 3'd3,
    StNoSpace  = 3'd4,
    StSeqErr   = 3'd5
  } status_e;

  typedef struct packed {
    op_e                op;
    logic               too_large;
    logic [WLenW-1:0]   write_length;
    logic [DataW-1:0]   data_in;
    logic [MaxLenW-1:0] max_length;
  } cmd_t;

endpackage

/* rtl/lpmr_if.sv */
// Valid/ready channel interfaces for the request and response sides of the ring.
// Depends on lpmr_pkg for the field widths.
interface lpmr_req_if;
  logic                         valid;
  logic                         ready;
  logic [lpmr_pkg::KindW-1:0]   kind;
  logic [lpmr_pkg::WLenW-1:0]   write_length;
  logic [lpmr_pkg::DataW-1:0]   data_in;
  logic [lpmr_pkg::MaxLenW-1:0] max_length;

  modport source (output valid, kind, write_length, data_in, max_length, input ready);
  modport sink (input valid, kind, write_length, data_in, max_length, output ready);
endinterface

interface lpmr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lpmr_pkg::StatusW-1:0] status;
  logic [lpmr_pkg::DataW-1:0]   data_out;
  logic [lpmr_pkg::WLenW-1:0]   msg_length;
  logic                         last_byte;

  modport source (output valid, status, data_out, msg_length, last_byte, input ready);
  modport sink (input valid, status, data_out, msg_length, last_byte, output ready);
endinterface

/* rtl/length_prefixed_message_ring_top.sv */
// Accept to response: front-end command register, command queue, ring engine, response
// register; payload reads add the RAM read, accepted headers the SWrHdr or SRdHdr state.
// Throughput is set by the ring engine and its single RAM read and write port: it takes
// a command only when idle with its response register free, and a payload read, a write
// header (four bytes, one a cycle) or a read header (four reads, one a cycle) holds it.
// Reset clears pointers, open flags and queues at once; ring contents stay undefined.
module length_prefixed_message_ring_top #(
  parameter int RING_BYTES = lpmr_pkg::RingBytes
) (
  input logic       clk_i,
  input logic       rst_ni,
  lpmr_req_if.sink  req_i,
  lpmr_rsp_if.source rsp_o
);

  logic           f_valid, f_ready;
  lpmr_pkg::cmd_t f_cmd;
  logic           q_valid, q_ready;
  lpmr_pkg::cmd_t q_cmd;

  lpmr_front #(
    .RING_BYTES (RING_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  lpmr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_cmd),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_cmd),
    .pop_ready_i  (q_ready)
  );

  lpmr_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .rsp_o       (rsp_o)
  );

endmodule

/* rtl/lpmr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package use.
module lpmr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lpmr_front.sv */
// Front end: takes request items, decodes the kind and flags oversize write headers.
// Depends on lpmr_pkg and lpmr_req_if.
module lpmr_front #(
  parameter int RING_BYTES = lpmr_pkg::RingBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpmr_req_if.sink       req_i,
  output logic           cmd_valid_o,
  output lpmr_pkg::cmd_t cmd_o,
  input  logic           cmd_ready_i
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int TW = (PW > lpmr_pkg::WLenW) ? PW : lpmr_pkg::WLenW;

  logic           cmd_valid_q;
  lpmr_pkg::cmd_t cmd_q;
  lpmr_pkg::cmd_t cmd_d;
  logic           accept;

  assign req_i.ready = !cmd_valid_q || cmd_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    cmd_d.op           = lpmr_pkg::op_e'(req_i.kind);
    cmd_d.too_large    = TW'(req_i.write_length) > TW'(RING_BYTES / 2);
    cmd_d.write_length = req_i.write_length;
    cmd_d.data_in      = req_i.data_in;
    cmd_d.max_length   = req_i.max_length;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* rtl/lpmr_fifo.sv */
// Short command queue between the front end and the ring engine.
// Depends on lpmr_pkg for the command type and depth.
module lpmr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  lpmr_pkg::cmd_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output lpmr_pkg::cmd_t pop_data_o,
  input  logic           pop_ready_i
);

  lpmr_pkg::cmd_t              mem_q [lpmr_pkg::QDepth];
  logic [lpmr_pkg::QAw-1:0]    wptr_q;
  logic [lpmr_pkg::QAw-1:0]    rptr_q;
  logic [lpmr_pkg::QAw:0]      cnt_q;
  logic                        push;
  logic                        pop;

  assign push_ready_o = cnt_q != (lpmr_pkg::QAw + 1)'(lpmr_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [lpmr_pkg::QAw-1:0] wrap(input logic [lpmr_pkg::QAw-1:0] p);
    wrap = (p == lpmr_pkg::QAw'(lpmr_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wrap(wptr_q);
      end
      if (pop) begin
        rptr_q <= wrap(rptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/lpmr_back.sv */
// Ring engine: runs queued commands against the byte ring and registers each response.
// Depends on lpmr_pkg, lpmr_rsp_if and lpmr_ram.
module lpmr_back #(
  parameter int RING_BYTES = lpmr_pkg::RingBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lpmr_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  lpmr_rsp_if.source     rsp_o
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int FW = (PW + 1 > lpmr_pkg::WLenW + 1) ? PW + 1 : lpmr_pkg::WLenW + 1;
  localparam int LW = lpmr_pkg::WLenW;
  localparam int DW = lpmr_pkg::DataW;

  typedef enum logic [1:0] {
    SIdle,
    SWrHdr,
    SRdHdr,
    SRdByte
  } state_e;

  state_e                  state_q;
  lpmr_pkg::cmd_t          cur_q;
  logic [PW-1:0]           cr_q, cw_q, rc_q, wc_q, ptr_q;
  logic [LW-1:0]           rl_q, wl_q;
  logic                    ro_q, wo_q;
  logic [1:0]              hcnt_q;
  logic [2:0]              iss_q;
  logic                    rvld_q;
  logic [lpmr_pkg::HdrW-1:0] hdr_q;

  logic                    out_valid_q;
  lpmr_pkg::status_e       status_q;
  logic [DW-1:0]           dout_q;
  logic [LW-1:0]           mlen_q;
  logic                    last_q;

  logic                    out_free, pop, no_space;
  logic [FW-1:0]           free_w;
  logic [lpmr_pkg::HdrW-1:0] wr_word, rd_len;
  logic [DW-1:0]           wbyte;
  logic                    we, re;
  logic [PW-1:0]           waddr, raddr;
  logic [DW-1:0]           wdata, rdata;

  logic                    res_valid;
  lpmr_pkg::status_e       res_status;
  logic [DW-1:0]           res_dout;
  logic [LW-1:0]           res_mlen;
  logic                    res_last;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (p == PW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == SIdle) && out_free;
  assign pop         = cmd_ready_o && cmd_valid_i;

  assign free_w   = FW'(RING_BYTES)
                  - (FW'(cw_q) - FW'(cr_q) + ((cw_q < cr_q) ? FW'(RING_BYTES) : FW'(0)));
  assign no_space = free_w <= FW'(cmd_i.write_length) + FW'(lpmr_pkg::HdrSlack);

  assign wr_word = lpmr_pkg::HdrW'(cur_q.write_length);
  assign wbyte   = wr_word[8*hcnt_q +: 8];
  assign rd_len  = {rdata, hdr_q[lpmr_pkg::HdrW-DW-1:0]};

  assign we    = (state_q == SWrHdr) || (pop && cmd_i.op == lpmr_pkg::OpWrByte && wo_q);
  assign waddr = (state_q == SWrHdr) ? ptr_q : wc_q;
  assign wdata = (state_q == SWrHdr) ? wbyte : cmd_i.data_in;
  assign re    = ((state_q == SRdHdr) && !iss_q[2])
              || (pop && cmd_i.op == lpmr_pkg::OpRdByte && ro_q);
  assign raddr = (state_q == SRdHdr) ? ptr_q : rc_q;

  lpmr_ram #(
    .Width (DW),
    .Depth (RING_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    res_valid  = 1'b0;
    res_status = lpmr_pkg::StOk;
    res_dout   = '0;
    res_mlen   = '0;
    res_last   = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (pop) begin
          unique case (cmd_i.op)
            lpmr_pkg::OpWrHdr: begin
              if (wo_q) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StSeqErr;
              end else if (cmd_i.too_large) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StTooLarge;
              end else if (no_space) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StNoSpace;
              end
            end
            lpmr_pkg::OpWrByte: begin
              res_valid = 1'b1;
              if (!wo_q) begin
                res_status = lpmr_pkg::StSeqErr;
              end else begin
                res_last = wl_q == LW'(1);
              end
            end
            lpmr_pkg::OpRdHdr: begin
              if (ro_q) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StSeqErr;
              end else if (cr_q == cw_q) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StEmpty;
              end
            end
            lpmr_pkg::OpRdByte: begin
              if (!ro_q) begin
                res_valid  = 1'b1;
                res_status = lpmr_pkg::StSeqErr;
              end
            end
          endcase
        end
      end
      SWrHdr: begin
        if (hcnt_q == 2'd3) begin
          res_valid = 1'b1;
          res_last  = cur_q.write_length == '0;
        end
      end
      SRdHdr: begin
        if (rvld_q && hcnt_q == 2'd3) begin
          res_valid = 1'b1;
          if (rd_len > lpmr_pkg::HdrW'(cur_q.max_length)) begin
            res_status = lpmr_pkg::StTooLong;
          end else begin
            res_mlen = rd_len[LW-1:0];
            res_last = rd_len == '0;
          end
        end
      end
      SRdByte: begin
        res_valid = 1'b1;
        res_dout  = rdata;
        res_last  = rl_q == LW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cur_q       <= '0;
      cr_q        <= '0;
      cw_q        <= '0;
      rc_q        <= '0;
      wc_q        <= '0;
      ptr_q       <= '0;
      rl_q        <= '0;
      wl_q        <= '0;
      ro_q        <= 1'b0;
      wo_q        <= 1'b0;
      hcnt_q      <= '0;
      iss_q       <= '0;
      rvld_q      <= 1'b0;
      hdr_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= lpmr_pkg::StOk;
      dout_q      <= '0;
      mlen_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      rvld_q <= re && (state_q == SRdHdr);
      if (res_valid) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
        dout_q      <= res_dout;
        mlen_q      <= res_mlen;
        last_q      <= res_last;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (pop) begin
            cur_q <= cmd_i;
            unique case (cmd_i.op)
              lpmr_pkg::OpWrHdr: begin
                if (!wo_q && !cmd_i.too_large && !no_space) begin
                  ptr_q   <= cw_q;
                  hcnt_q  <= '0;
                  state_q <= SWrHdr;
                end
              end
              lpmr_pkg::OpWrByte: begin
                if (wo_q) begin
                  wc_q <= nxt(wc_q);
                  wl_q <= wl_q - 1'b1;
                  if (wl_q == LW'(1)) begin
                    cw_q <= nxt(wc_q);
                    wo_q <= 1'b0;
                  end
                end
              end
              lpmr_pkg::OpRdHdr: begin
                if (!ro_q && cr_q != cw_q) begin
                  ptr_q   <= cr_q;
                  hcnt_q  <= '0;
                  iss_q   <= '0;
                  state_q <= SRdHdr;
                end
              end
              lpmr_pkg::OpRdByte: begin
                if (ro_q) begin
                  state_q <= SRdByte;
                end
              end
            endcase
          end
        end
        SWrHdr: begin
          ptr_q  <= nxt(ptr_q);
          hcnt_q <= hcnt_q + 1'b1;
          if (hcnt_q == 2'd3) begin
            wc_q    <= nxt(ptr_q);
            wl_q    <= cur_q.write_length;
            state_q <= SIdle;
            if (cur_q.write_length == '0) begin
              cw_q <= nxt(ptr_q);
            end else begin
              wo_q <= 1'b1;
            end
          end
        end
        SRdHdr: begin
          if (!iss_q[2]) begin
            ptr_q <= nxt(ptr_q);
            iss_q <= iss_q + 1'b1;
          end
          if (rvld_q) begin
            hdr_q[8*hcnt_q +: 8] <= rdata;
            hcnt_q               <= hcnt_q + 1'b1;
            if (hcnt_q == 2'd3) begin
              state_q <= SIdle;
              if (rd_len <= lpmr_pkg::HdrW'(cur_q.max_length)) begin
                rc_q <= ptr_q;
                rl_q <= rd_len[LW-1:0];
                if (rd_len == '0) begin
                  cr_q <= ptr_q;
                end else begin
                  ro_q <= 1'b1;
                end
              end
            end
          end
        end
        SRdByte: begin
          rc_q    <= nxt(rc_q);
          rl_q    <= rl_q - 1'b1;
          state_q <= SIdle;
          if (rl_q == LW'(1)) begin
            cr_q <= nxt(rc_q);
            ro_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.data_out   = dout_q;
  assign rsp_o.msg_length = mlen_q;
  assign rsp_o.last_byte  = last_q;

endmodule
